### rtl/pfa_pkg.sv
package pfa_pkg;

  localparam logic [2:0] FUNC_ALLOC  = 3'd0;
  localparam logic [2:0] FUNC_FREE   = 3'd1;
  localparam logic [2:0] FUNC_INCREF = 3'd2;
  localparam logic [2:0] FUNC_DECREF = 3'd3;
  localparam logic [2:0] FUNC_GETREF = 3'd4;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam int unsigned KERN_SPAN_RST = 1024;

  typedef struct packed {
    logic [2:0]  func;
    logic        kern_sel;
    logic [11:0] page_index;
    logic        address_valid;
  } pfa_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] page_out;
    logic [15:0] ref_count;
    logic        page_freed;
  } pfa_rsp_t;

  typedef struct packed {
    logic restart;
    logic load;
    logic exec;
    logic clr;
  } pfa_cmd_t;

  typedef struct packed {
    logic clr_last;
  } pfa_sts_t;

endpackage

### rtl/page_frame_allocator_refcount.sv
// Channel   Direction  Handshake                    Payload
// request   in         start, busy                  req_i  (pfa_req_t)
// result    out        done_o (one-cycle strobe)    rsp_o  (pfa_rsp_t)
// config    in         cfg_valid_i, cfg_ready_o     cfg_data_i (kernel region size)
//
// Per item: the accept reads the count and stack memories into registers, the
// execute state writes them back and registers the result, done_o rising with
// it; a new item is taken only in idle. After reset and every config write the
// block sweeps both memories, one entry a cycle over all entries, busy high.
// Results cannot be stalled; config writes are taken only while idle with start low.
module page_frame_allocator_refcount #(
  parameter int unsigned PAGE_COUNT  = 4096,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  pfa_pkg::pfa_req_t req_i,
  output logic              done_o,
  output pfa_pkg::pfa_rsp_t rsp_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [11:0]       cfg_data_i
);
  import pfa_pkg::*;

  pfa_cmd_t cmd;
  pfa_sts_t sts;

  pfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .cfg_valid_i (cfg_valid_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy        (busy),
    .done_o      (done_o),
    .cfg_ready_o (cfg_ready_o)
  );

  pfa_dpath #(
    .PAGE_COUNT  (PAGE_COUNT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_i),
    .sts_o      (sts),
    .rsp_o      (rsp_o)
  );

endmodule

### rtl/pfa_ctrl.sv
module pfa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              cfg_valid_i,
  input  pfa_pkg::pfa_sts_t sts_i,
  output pfa_pkg::pfa_cmd_t cmd_o,
  output logic              busy,
  output logic              done_o,
  output logic              cfg_ready_o
);
  import pfa_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_INIT = 2'd2;

  logic [1:0] state_q, state_d;
  logic       done_q;
  logic       cfg_rdy;
  logic       cfg_take;

  // config only taken while idle and no item is being offered
  assign cfg_rdy  = (state_q == S_IDLE) && !start;
  assign cfg_take = cfg_valid_i && cfg_rdy;

  always_comb begin
    state_d = state_q;
    if (cfg_take) begin
      state_d = S_INIT;
    end else begin
      unique case (state_q)
        S_IDLE: if (start) state_d = S_EXEC;
        S_EXEC: state_d = S_IDLE;
        S_INIT: if (sts_i.clr_last) state_d = S_IDLE;
        default: state_d = S_INIT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_EXEC);
    end
  end

  assign cmd_o.restart = cfg_take;
  assign cmd_o.load    = (state_q == S_IDLE) && start;
  assign cmd_o.exec    = (state_q == S_EXEC);
  assign cmd_o.clr     = (state_q == S_INIT);

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign cfg_ready_o = cfg_rdy;

endmodule

### rtl/pfa_dpath.sv
module pfa_dpath #(
  parameter int unsigned PAGE_COUNT  = 4096,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfa_pkg::pfa_cmd_t cmd_i,
  input  logic [11:0]       cfg_data_i,
  input  pfa_pkg::pfa_req_t req_i,
  output pfa_pkg::pfa_sts_t sts_o,
  output pfa_pkg::pfa_rsp_t rsp_o
);
  import pfa_pkg::*;

  localparam int unsigned AW     = $clog2(PAGE_COUNT);
  localparam int unsigned TW     = $clog2(PAGE_COUNT + 1);
  localparam int unsigned KP_RST =
    (PAGE_COUNT < KERN_SPAN_RST) ? PAGE_COUNT : KERN_SPAN_RST;

  logic [AW-1:0]          stack_mem [PAGE_COUNT];
  logic [COUNT_WIDTH-1:0] count_mem [PAGE_COUNT];

  logic [TW-1:0] kp_q, ktop_q, ktop_d, utop_q, utop_d, kp_new;
  logic [AW-1:0] clr_cnt_q;

  pfa_req_t               req_q;
  logic                   valid_q;
  logic [AW-1:0]          stack_rd_q;
  logic [COUNT_WIDTH-1:0] cnt_rd_q;
  pfa_rsp_t               rsp_q, rsp_d;

  logic [TW-1:0] sel_top, sel_base, user_cap;
  logic [AW-1:0] slot, page_a;

  logic                   stack_we, count_we;
  logic [AW-1:0]          stack_wa, count_wa, stack_wd;
  logic [COUNT_WIDTH-1:0] count_wd, cnt_new;

  logic          in_region, stack_full;
  logic [1:0]    push_st;
  logic [AW-1:0] push_addr;
  logic          push_en;

  function automatic logic sel_top_q_zero(input logic k, input logic [TW-1:0] kt,
                                          input logic [TW-1:0] ut);
    sel_top_q_zero = k ? (kt == '0) : (ut == '0);
  endfunction

  assign kp_new = (32'(cfg_data_i) > 32'(PAGE_COUNT)) ? TW'(PAGE_COUNT) : TW'(cfg_data_i);

  // read side, used in the accept cycle
  assign sel_top  = req_i.kern_sel ? ktop_q : utop_q;
  assign sel_base = req_i.kern_sel ? '0 : kp_q;
  assign slot     = AW'(sel_base + sel_top - TW'(1));

  // push into the chosen region
  assign page_a   = AW'(req_q.page_index);
  assign user_cap = TW'(PAGE_COUNT) - kp_q;
  always_comb begin
    if (req_q.kern_sel) begin
      in_region  = 32'(req_q.page_index) < 32'(kp_q);
      stack_full = ktop_q >= kp_q;
      push_addr  = AW'(ktop_q);
    end else begin
      in_region  = 32'(req_q.page_index) >= 32'(kp_q);
      stack_full = utop_q >= user_cap;
      push_addr  = AW'(kp_q + utop_q);
    end
    if (!in_region)     push_st = ST_IGNORED;
    else if (stack_full) push_st = ST_FULL;
    else                push_st = ST_DONE;
  end

  always_comb begin
    rsp_d    = '0;
    rsp_d.status = ST_IGNORED;
    ktop_d   = ktop_q;
    utop_d   = utop_q;
    count_we = 1'b0;
    count_wa = page_a;
    count_wd = cnt_rd_q;
    push_en  = 1'b0;
    cnt_new  = cnt_rd_q;
    if (req_q.func == FUNC_ALLOC) begin
      if (sel_top_q_zero(req_q.kern_sel, ktop_q, utop_q)) begin
        rsp_d.status = ST_EMPTY;
      end else begin
        rsp_d.status    = ST_DONE;
        rsp_d.page_out  = 12'(stack_rd_q);
        rsp_d.ref_count = 16'd1;
        count_we = 1'b1;
        count_wa = stack_rd_q;
        count_wd = COUNT_WIDTH'(1);
        if (req_q.kern_sel) ktop_d = ktop_q - TW'(1);
        else                utop_d = utop_q - TW'(1);
      end
    end else if (valid_q) begin
      case (req_q.func)
        FUNC_FREE: begin
          rsp_d.status     = push_st;
          rsp_d.ref_count  = 16'(cnt_rd_q);
          push_en          = (push_st == ST_DONE);
        end
        FUNC_INCREF: begin
          if (cnt_rd_q != {COUNT_WIDTH{1'b1}}) cnt_new = cnt_rd_q + COUNT_WIDTH'(1);
          count_we        = 1'b1;
          count_wd        = cnt_new;
          rsp_d.status    = ST_DONE;
          rsp_d.ref_count = 16'(cnt_new);
        end
        FUNC_DECREF: begin
          if (cnt_rd_q != '0) cnt_new = cnt_rd_q - COUNT_WIDTH'(1);
          count_we        = 1'b1;
          count_wd        = cnt_new;
          rsp_d.status    = ST_DONE;
          rsp_d.ref_count = 16'(cnt_new);
          if (cnt_new == '0) begin
            rsp_d.status = push_st;
            push_en      = (push_st == ST_DONE);
          end
        end
        FUNC_GETREF: begin
          rsp_d.status    = ST_DONE;
          rsp_d.ref_count = 16'(cnt_rd_q);
        end
        default: rsp_d.status = ST_IGNORED;
      endcase
    end
    rsp_d.page_freed = push_en;
    if (push_en) begin
      if (req_q.kern_sel) ktop_d = ktop_q + TW'(1);
      else                utop_d = utop_q + TW'(1);
    end
  end

  // memory write ports: clearing pass or execute
  always_comb begin
    if (cmd_i.clr) begin
      stack_we = 1'b1;
      stack_wa = clr_cnt_q;
      stack_wd = clr_cnt_q;
    end else begin
      stack_we = cmd_i.exec && push_en;
      stack_wa = push_addr;
      stack_wd = page_a;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) stack_mem[stack_wa] <= stack_wd;
    if (cmd_i.load) stack_rd_q <= stack_mem[slot];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) count_mem[clr_cnt_q] <= '0;
    else if (cmd_i.exec && count_we) count_mem[count_wa] <= count_wd;
    if (cmd_i.load) cnt_rd_q <= count_mem[AW'(req_i.page_index)];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= req_i;
      valid_q <= req_i.address_valid && (32'(req_i.page_index) < 32'(PAGE_COUNT));
    end
    if (cmd_i.exec) rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q      <= TW'(KP_RST);
      ktop_q    <= TW'(KP_RST);
      utop_q    <= TW'(PAGE_COUNT - KP_RST);
      clr_cnt_q <= '0;
    end else if (cmd_i.restart) begin
      kp_q      <= kp_new;
      ktop_q    <= kp_new;
      utop_q    <= TW'(PAGE_COUNT) - kp_new;
      clr_cnt_q <= '0;
    end else begin
      if (cmd_i.exec) begin
        ktop_q <= ktop_d;
        utop_q <= utop_d;
      end
      if (cmd_i.clr) clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  assign sts_o.clr_last = (clr_cnt_q == AW'(PAGE_COUNT - 1));
  assign rsp_o          = rsp_q;

endmodule
